/* sv/masked_byte_signature_search_core_macros.svh */
// assertion macros shared by the signature search modules
`ifndef MASKED_BYTE_SIGNATURE_SEARCH_CORE_MACROS_SVH
`define MASKED_BYTE_SIGNATURE_SEARCH_CORE_MACROS_SVH

// checked only while out of reset
`define MSSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define MSSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/msss_pkg.sv */
// shared constants and types of the signature search block
package msss_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int CFG_W       = 6;
    localparam int LOAD_IDX_W  = 5;
    localparam int ADDR_W      = 2;
    localparam int DATA_W      = 32;
    localparam int OFFSET_W    = 32;

    localparam logic              ACT_LOAD = 1'b0;
    localparam logic              ACT_SCAN = 1'b1;

    localparam logic [ADDR_W-1:0] ADDR_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_W-1:0]  LEN_RESET           = 6'd1;

    localparam logic [OFFSET_W-1:0] COUNT_MAX = {OFFSET_W{1'b1}};

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] offset;
    } res_t;

endpackage

/* sv/msss_cell.sv */
// one window cell: a pattern byte with its care bit and one window byte
module msss_cell (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift_en,
    input  logic       clear,
    input  logic [7:0] win_in,
    output logic [7:0] win_out,
    input  logic       load_en,
    input  logic [7:0] load_byte,
    input  logic       load_care,
    input  logic       active,
    input  logic [7:0] cmp_byte,
    output logic       hit
);

    logic [7:0] win_reg;
    logic [7:0] win_next;
    logic [7:0] pat_reg;
    logic       care_reg;

    always_comb
    begin
        win_next = win_reg;
        if (clear)
        begin
            win_next = 8'd0;
        end
        else if (shift_en)
        begin
            win_next = win_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= 8'd0;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    // pattern entries stay undefined until loaded
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            pat_reg  <= load_byte;
            care_reg <= load_care;
        end
    end

    assign win_out = win_reg;
    assign hit     = !active || !care_reg || (cmp_byte == pat_reg);

endmodule

/* sv/msss_out_buf.sv */
// two-stage result buffer: output register plus skid stage
module msss_out_buf
    import msss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_res,
    output logic full,
    output logic out_valid,
    input  logic out_stall,
    output res_t out_res
);

    `include "masked_byte_signature_search_core_macros.svh"

    logic out_valid_reg;
    logic out_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    res_t out_res_reg;
    res_t out_res_next;
    res_t skid_res_reg;
    res_t skid_res_next;
    logic out_take;

    assign out_take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_res_next   = push_res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_res_next   = push_res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    `MSSS_ASSERT_ALWAYS(a_skid_implies_out, skid_valid_reg |-> out_valid_reg, "skid full while output empty")
    `MSSS_ASSERT(a_no_push_when_full, push |-> !skid_valid_reg, "result pushed into full buffer")
    `MSSS_ASSERT(a_drain_empties, (out_take && !push && !skid_valid_reg) |=> !out_valid_reg, "output not freed after transfer")

endmodule

/* sv/masked_byte_signature_search_core.sv */
// Masked byte signature search. Load items (action 0) write one pattern byte and its care bit
// into the cell addressed by load_index; scan items (action 1) shift one memory byte into a
// sliding window held across a row of cells. Every scan byte is compared against the whole
// pattern in parallel in the cycle it is accepted, so one item is taken per clock while in_stall
// is low; a result (first match offset, or not found when last closes a region with no match)
// goes to the output register, or to the skid stage if that one is stalled. in_stall rises only
// when the output register and the skid stage both hold results not yet taken. pattern_length
// is written at APB address 0; 0 acts as 1 and values above the cell count act as that count.
module masked_byte_signature_search_core
    import msss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    // input items
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  action,
    input  logic [7:0]            data_byte,
    input  logic                  care,
    input  logic [LOAD_IDX_W-1:0] load_index,
    input  logic                  last,
    // results
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  found,
    output logic [OFFSET_W-1:0]   offset
);

    `include "masked_byte_signature_search_core_macros.svh"

    logic [CFG_W-1:0]    len_reg;
    logic [CFG_W-1:0]    len_next;
    logic [OFFSET_W-1:0] count_reg;
    logic [OFFSET_W-1:0] count_next;
    logic                done_reg;
    logic                done_next;

    logic                cfg_wr;
    logic                in_acc;
    logic                scan_acc;
    logic                load_acc;
    logic                load_ok;
    logic [LEN_W-1:0]    n_use;
    logic                test_en;
    logic [OFFSET_W-1:0] count_inc;
    logic                all_hit;
    logic                match;
    logic                res_push;
    res_t                res_in;
    res_t                res_out;
    logic                buf_full;

    logic [7:0]             tap   [MAX_PATTERN];
    logic [7:0]             win_q [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] hit;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_PATTERN_LENGTH);
    assign prdata = (paddr == ADDR_PATTERN_LENGTH) ? DATA_W'(len_reg) : '0;

    always_comb
    begin
        len_next = len_reg;
        if (cfg_wr)
        begin
            len_next = pwdata[CFG_W-1:0];
        end
    end

    // length in use, clamped to 1..MAX_PATTERN
    always_comb
    begin
        if (len_reg == '0)
        begin
            n_use = LEN_W'(1);
        end
        else if (32'(len_reg) > 32'(MAX_PATTERN))
        begin
            n_use = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            n_use = LEN_W'(len_reg);
        end
    end

    assign in_stall = buf_full;
    assign in_acc   = in_valid && !in_stall;
    assign scan_acc = in_acc && (action == ACT_SCAN);
    assign load_acc = in_acc && (action == ACT_LOAD);
    assign load_ok  = 32'(load_index) < 32'(MAX_PATTERN);

    // window taps after this cycle's shift, newest at 0
    assign tap[0] = data_byte;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN; gi++)
        begin : g_cell
            logic [LEN_W-1:0] lane_pos;
            logic             lane_act;

            if (gi > 0)
            begin : g_tap
                assign tap[gi] = win_q[gi-1];
            end

            // pattern byte gi lines up with window tap n-1-gi
            assign lane_act = LEN_W'(gi) < n_use;
            assign lane_pos = n_use - LEN_W'(1) - LEN_W'(gi);

            msss_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift_en  (scan_acc),
                .clear     (scan_acc && last),
                .win_in    (tap[gi]),
                .win_out   (win_q[gi]),
                .load_en   (load_acc && load_ok && (32'(load_index) == gi)),
                .load_byte (data_byte),
                .load_care (care),
                .active    (lane_act),
                .cmp_byte  (tap[lane_pos[IDX_W-1:0]]),
                .hit       (hit[gi])
            );
        end
    endgenerate

    assign all_hit   = &hit;
    assign test_en   = !done_reg && (count_reg != COUNT_MAX);
    assign count_inc = count_reg + OFFSET_W'(1);
    assign match     = test_en && (count_inc >= OFFSET_W'(n_use)) && all_hit;

    always_comb
    begin
        count_next = count_reg;
        done_next  = done_reg;
        if (scan_acc)
        begin
            if (last)
            begin
                count_next = '0;
                done_next  = 1'b0;
            end
            else
            begin
                if (test_en)
                begin
                    count_next = count_inc;
                end
                done_next = done_reg || match;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= LEN_RESET;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // a match wins over the end-of-region report
    assign res_push      = scan_acc && (match || (last && !done_reg));
    assign res_in.found  = match;
    assign res_in.offset = match ? (count_inc - OFFSET_W'(n_use)) : '0;

    msss_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_res  (res_in),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (res_out)
    );

    assign found  = res_out.found;
    assign offset = res_out.offset;

    `MSSS_ASSERT(a_last_ends_region, (scan_acc && last) |=> (count_reg == '0) && !done_reg, "region state not cleared after last byte")
    `MSSS_ASSERT(a_one_match_per_region, (scan_acc && done_reg) |-> !match, "second match in one region")
    `MSSS_ASSERT(a_offset_in_range, (res_push && res_in.found) |-> (res_in.offset < count_inc), "match offset beyond bytes scanned")

endmodule
